@@ hw/rtl/mpfd_pkg.sv @@
// Package for the page-mode monochrome framebuffer drawer.
// Command codes, queue entry type, 5x7 font table. No dependencies.
package mpfd_pkg;

  localparam int DEF_PANEL_WIDTH = 128;
  localparam int DEF_PAGE_COUNT  = 8;
  localparam int GLYPH_COLS      = 5;
  localparam int GLYPH_ROWS      = 7;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_PIXEL   = 3'd1;
  localparam logic [2:0] CMD_HLINE   = 3'd2;
  localparam logic [2:0] CMD_VLINE   = 3'd3;
  localparam logic [2:0] CMD_OUTLINE = 3'd4;
  localparam logic [2:0] CMD_FILL    = 3'd5;
  localparam logic [2:0] CMD_GLYPH   = 3'd6;
  localparam logic [2:0] CMD_READ    = 3'd7;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_OUTLINE = 2'd1,
    MODE_GLYPH   = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    mode_t       mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  cols;
    logic [7:0]  rows;
    logic [7:0]  code;
    logic [9:0]  addr;
  } job_t;

  // columns packed {c4,c3,c2,c1,c0}
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      8'h32: g = {8'h46, 8'h49, 8'h49, 8'h51, 8'h62};
      8'h33: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h22};
      8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      8'h35: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h2F};
      8'h36: g = {8'h32, 8'h49, 8'h49, 8'h49, 8'h3E};
      8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h26};
      8'h41: g = {8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E};
      8'h42: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      8'h43: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h44: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      8'h45: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      8'h47: g = {8'h3A, 8'h49, 8'h49, 8'h41, 8'h3E};
      8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4A: g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
      8'h4B: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      8'h4C: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      8'h51: g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
      8'h52: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      8'h53: g = {8'h32, 8'h49, 8'h49, 8'h49, 8'h26};
      8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h59: g = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
      8'h5A: g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      8'h2B: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/mpfd_front.sv @@
// Front end: decodes stream commands into draw jobs.
// Depends on mpfd_pkg.
module mpfd_front import mpfd_pkg::*; (
  input  logic [2:0] command,
  input  logic [7:0] x_pos,
  input  logic [7:0] y_pos,
  input  logic [7:0] line_length,
  input  logic [7:0] rect_width,
  input  logic [7:0] rect_height,
  input  logic [7:0] char_code,
  input  logic [9:0] read_address,
  output job_t       job
);

  always_comb begin
    job.kind = KIND_DRAW;
    job.mode = MODE_SOLID;
    job.x    = x_pos;
    job.y    = y_pos;
    job.cols = 8'd1;
    job.rows = 8'd1;
    job.code = char_code;
    job.addr = read_address;
    case (command)
      CMD_CLEAR: job.kind = KIND_CLEAR;
      CMD_PIXEL: ;
      CMD_HLINE: job.cols = line_length;
      CMD_VLINE: job.rows = line_length;
      CMD_OUTLINE: begin
        job.mode = MODE_OUTLINE;
        job.cols = rect_width;
        job.rows = rect_height;
      end
      CMD_FILL: begin
        job.cols = rect_width;
        job.rows = rect_height;
      end
      CMD_GLYPH: begin
        job.mode = MODE_GLYPH;
        job.cols = 8'(GLYPH_COLS);
        job.rows = 8'(GLYPH_ROWS);
      end
      CMD_READ: job.kind = KIND_READ;
      default: job.kind = KIND_READ;
    endcase
  end

endmodule

@@ hw/rtl/mpfd_queue.sv @@
// Two-entry job queue between front end and drawing engine.
// Depends on mpfd_pkg.
module mpfd_queue import mpfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hw/rtl/mpfd_back.sv @@
// Drawing engine: pixel scan with read-modify-write of the page store,
// clear sweep, byte read, result register. Depends on mpfd_pkg.
module mpfd_back import mpfd_pkg::*; #(
  parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
  parameter int PAGE_COUNT  = DEF_PAGE_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job_in,
  output logic       job_pop,
  output logic       init_busy,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] res_data,
  output logic       res_read
);

  localparam int STORE = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int ROWS  = PAGE_COUNT * 8;

  typedef enum logic [6:0] {
    ST_INIT = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_CLR  = 7'b0000100,
    ST_SCAN = 7'b0001000,
    ST_WR   = 7'b0010000,
    ST_RDW  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t          state;
  job_t            job;
  logic [7:0]      col;
  logic [7:0]      row;
  logic [AW-1:0]   cnt;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_bit;
  logic [7:0]      rd_q;
  logic [7:0]      result;
  logic [7:0]      mem [STORE];

  logic [7:0]      px;
  logic [7:0]      py;
  logic            on_panel;
  logic            shape_hit;
  logic            hit;
  logic [AW-1:0]   pix_addr;
  logic [AW-1:0]   rd_addr;
  logic            last_col;
  logic            last_row;
  logic            rd_in_range;
  logic [39:0]     gbits;
  logic            out_free;

  assign px       = job.x + col;
  assign py       = job.y + row;
  assign on_panel = ({1'b0, px} < 9'(PANEL_WIDTH)) && ({1'b0, py} < 9'(ROWS));
  assign pix_addr = AW'(int'(py[7:3]) * PANEL_WIDTH + int'(px));
  assign gbits    = glyph_bits(job.code);
  assign last_col = (col == job.cols - 8'd1);
  assign last_row = (row == job.rows - 8'd1);
  assign rd_in_range = ({22'd0, job_in.addr} < 32'(STORE));
  assign out_free = !res_valid || res_ready;

  always_comb begin
    case (job.mode)
      MODE_OUTLINE: shape_hit = (row == 8'd0) || last_row || (col == 8'd0) || last_col;
      MODE_GLYPH:   shape_hit = gbits[{col[2:0], row[2:0]}];
      default:      shape_hit = 1'b1;
    endcase
  end
  assign hit = on_panel && shape_hit;

  assign rd_addr   = (state == ST_IDLE) ? AW'(job_in.addr) : pix_addr;
  assign job_pop   = (state == ST_IDLE) && job_valid;
  assign init_busy = (state == ST_INIT);

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (state == ST_INIT || state == ST_CLR) begin
      mem[cnt] <= 8'd0;
    end else if (state == ST_WR) begin
      mem[wr_addr] <= rd_q | wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_INIT, ST_CLR: begin
          if (cnt == AW'(STORE - 1)) begin
            cnt   <= '0;
            state <= (state == ST_INIT) ? ST_IDLE : ST_DONE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (job_valid) begin
            job    <= job_in;
            col    <= 8'd0;
            row    <= 8'd0;
            result <= 8'd0;
            case (job_in.kind)
              KIND_CLEAR: state <= ST_CLR;
              KIND_READ:  state <= rd_in_range ? ST_RDW : ST_DONE;
              default: begin
                state <= (job_in.cols == 8'd0 || job_in.rows == 8'd0) ? ST_DONE : ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN, ST_WR: begin
          if (state == ST_SCAN && hit) begin
            wr_addr <= pix_addr;
            wr_bit  <= 8'd1 << py[2:0];
            state   <= ST_WR;
          end else begin
            if (last_col) begin
              col   <= 8'd0;
              row   <= row + 8'd1;
              state <= last_row ? ST_DONE : ST_SCAN;
            end else begin
              col   <= col + 8'd1;
              state <= ST_SCAN;
            end
          end
        end
        ST_RDW: begin
          result <= rd_q;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            res_data  <= result;
            res_read  <= (job.kind == KIND_READ);
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/mono_page_framebuffer_drawer.sv @@
// Top level of the page-mode monochrome framebuffer drawer.
// Depends on mpfd_pkg, mpfd_front, mpfd_queue, mpfd_back.
//
//  channel | dir | tdata                         | tuser
//  s_*     | in  | x,y,len,w,h,code,addr (64b)   | command
//  m_*     | out | read_data                     | was_read
//
// After a transfer the job is registered in the queue; the engine takes it when
// idle. A draw then scans cols*rows positions, with a read-modify-write of its
// byte for each pixel written; a read passes a byte read step (skipped when out
// of range), a clear sweeps all PANEL_WIDTH*PAGE_COUNT bytes, and a final step
// loads the result. After reset a clearing pass over PANEL_WIDTH*PAGE_COUNT
// bytes runs with s_tready low. A two-entry queue lets input go on while the
// engine works; a stalled output holds the engine in its final step.
module mono_page_framebuffer_drawer import mpfd_pkg::*; #(
  parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
  parameter int PAGE_COUNT  = DEF_PAGE_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // x_pos, y_pos, line_length, rect_width,
                                // rect_height, char_code, read_address, 0
  input  logic [2:0]  s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // read_data
  output logic        m_tuser   // was_read
);

  job_t dec_job;
  job_t head;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic init_busy;
  logic push;

  assign s_tready = !q_full && !init_busy;
  assign push     = s_tvalid && s_tready;

  mpfd_front u_front (
    .command      (s_tuser),
    .x_pos        (s_tdata[7:0]),
    .y_pos        (s_tdata[15:8]),
    .line_length  (s_tdata[23:16]),
    .rect_width   (s_tdata[31:24]),
    .rect_height  (s_tdata[39:32]),
    .char_code    (s_tdata[47:40]),
    .read_address (s_tdata[57:48]),
    .job          (dec_job)
  );

  mpfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (dec_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head)
  );

  mpfd_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job_in    (head),
    .job_pop   (q_pop),
    .init_busy (init_busy),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_data  (m_tdata),
    .res_read  (m_tuser)
  );

endmodule

@@ hw/rtl/mpfd_checker.sv @@
// Port-level checks for the framebuffer drawer, bound to the top level.
// Depends on mono_page_framebuffer_drawer.
module mpfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_draw_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("non-read result carries data");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_rst_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

endmodule

bind mono_page_framebuffer_drawer mpfd_checker u_mpfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
